>>> design/ptts_pkg.sv
// Shared types and constants of the periodic task tick scheduler.
package ptts_pkg;

    localparam int TICK_W      = 16;
    localparam int SLOT_W      = 3;
    localparam int MODE_W      = 3;
    localparam int MOD_CNT_W   = 4;
    localparam int TASK_SLOTS_DEFAULT = 8;

    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd4;

    localparam logic KIND_DUE    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_REJ = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] period;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] due_slot;
        logic [TICK_W-1:0] tick_value;
        logic              status;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DIV,
        S_PUSH,
        S_FLUSH
    } t_state;

endpackage

>>> design/periodic_task_tick_scheduler_core.sv
// Top level of the periodic task tick scheduler: slot table, sequencer, output stage.
//
//  Channel | Direction | Handshake               | Payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_item (t_out_item)
//
// A command passes from S_IDLE through S_FLUSH and yields one status transaction.
// A tick walks all slots; each live slot goes through the registered period memory
// read and, for a nonzero period, the 16-step remainder unit.
// Reset clears the tick counter and all present and running flags at once.
// A stalled output holds the sequencer when a second due result is ready and
// at the end of each transaction while its final result still waits.
module periodic_task_tick_scheduler_core
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

    t_state                r_state, n_state;
    logic [TICK_W-1:0]     r_tick;
    logic [IDX_W-1:0]      r_idx;
    logic [TASK_SLOTS-1:0] r_present;
    logic [TASK_SLOTS-1:0] r_running;
    logic [TICK_W-1:0]     r_mem [TASK_SLOTS];
    logic [TICK_W-1:0]     r_rd_data;
    t_out_item             r_pend;
    logic                  r_pend_v;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic              w_accept;
    logic              w_out_free;
    logic              w_elig;
    logic              w_last_idx;
    logic              w_hit;
    logic              w_slot_ok;
    logic [IDX_W-1:0]  w_cmd_idx;
    logic              w_cmd_ok;
    logic              w_mod_done;
    logic [TICK_W-1:0] w_mod_rem;
    t_out_item         w_out_nxt;

    logic c_start_mod;
    logic c_adv;
    logic c_pend_load;
    logic c_out_load;
    logic c_out_last;
    logic c_pend_clr;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_elig     = r_present[r_idx] && r_running[r_idx];
    assign w_last_idx = r_idx == LAST_IDX;
    assign w_hit      = w_mod_rem == '0;
    assign w_slot_ok  = {{(32-SLOT_W){1'b0}}, i_in_item.slot} < 32'(TASK_SLOTS);
    assign w_cmd_idx  = IDX_W'(i_in_item.slot);

    always_comb begin
        w_cmd_ok = 1'b0;
        if (w_slot_ok) begin
            unique case (i_in_item.mode)
                MODE_CREATE:  w_cmd_ok = !r_present[w_cmd_idx];
                MODE_DELETE,
                MODE_SUSPEND,
                MODE_RESUME:  w_cmd_ok = 1'b1;
                default:      w_cmd_ok = 1'b0;
            endcase
        end
    end

    ptts_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_start_mod),
        .i_dividend (r_tick),
        .i_divisor  (r_rd_data),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_item.mode == MODE_TICK) ? S_SCAN : S_FLUSH;
                end
            end
            S_SCAN: begin
                if (w_elig) begin
                    n_state = S_READ;
                end else if (w_last_idx) begin
                    n_state = S_FLUSH;
                end
            end
            S_READ: begin
                if (r_rd_data != '0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = w_last_idx ? S_FLUSH : S_SCAN;
                end
            end
            S_DIV: begin
                if (w_mod_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!(w_hit && r_pend_v && !w_out_free)) begin
                    n_state = w_last_idx ? S_FLUSH : S_SCAN;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        c_start_mod = 1'b0;
        c_adv       = 1'b0;
        c_pend_load = 1'b0;
        c_out_load  = 1'b0;
        c_out_last  = 1'b0;
        c_pend_clr  = 1'b0;
        unique case (r_state)
            S_SCAN: begin
                c_adv = !w_elig && !w_last_idx;
            end
            S_READ: begin
                c_start_mod = r_rd_data != '0;
                c_adv       = (r_rd_data == '0) && !w_last_idx;
            end
            S_PUSH: begin
                if (!(w_hit && r_pend_v && !w_out_free)) begin
                    c_adv       = !w_last_idx;
                    c_pend_load = w_hit;
                    c_out_load  = w_hit && r_pend_v;
                end
            end
            S_FLUSH: begin
                c_out_last = 1'b1;
                c_out_load = r_pend_v && w_out_free;
                c_pend_clr = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_out_nxt      = r_pend;
        w_out_nxt.last = c_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_idx       <= '0;
            r_present   <= '0;
            r_running   <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_idx <= '0;
                if (i_in_item.mode == MODE_TICK) begin
                    r_tick <= r_tick + 1'b1;
                end else begin
                    r_pend_v <= 1'b1;
                    if (w_cmd_ok) begin
                        unique case (i_in_item.mode)
                            MODE_CREATE: begin
                                r_present[w_cmd_idx] <= 1'b1;
                                r_running[w_cmd_idx] <= 1'b1;
                            end
                            MODE_DELETE:  r_present[w_cmd_idx] <= 1'b0;
                            MODE_SUSPEND: r_running[w_cmd_idx] <= 1'b0;
                            MODE_RESUME:  r_running[w_cmd_idx] <= 1'b1;
                            default: begin
                            end
                        endcase
                    end
                end
            end else begin
                if (c_adv) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (c_pend_load) begin
                    r_pend_v <= 1'b1;
                end else if (c_pend_clr) begin
                    r_pend_v <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in_item.mode == MODE_CREATE) && w_cmd_ok) begin
            r_mem[w_cmd_idx] <= i_in_item.period;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend.kind       <= KIND_STATUS;
            r_pend.due_slot   <= i_in_item.slot;
            r_pend.tick_value <= r_tick;
            r_pend.status     <= w_cmd_ok ? STATUS_OK : STATUS_REJ;
            r_pend.last       <= 1'b1;
        end else if (c_pend_load) begin
            r_pend.kind       <= KIND_DUE;
            r_pend.due_slot   <= SLOT_W'(r_idx);
            r_pend.tick_value <= r_tick;
            r_pend.status     <= STATUS_OK;
            r_pend.last       <= 1'b0;
        end
        if (c_out_load) begin
            r_out <= w_out_nxt;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> design/ptts_mod.sv
// Bit-serial remainder unit: one restoring division step per cycle.
module ptts_mod
    import ptts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W-1:0] i_dividend,
    input  logic [TICK_W-1:0] i_divisor,
    output logic              o_done,
    output logic [TICK_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [TICK_W-1:0]    r_num;
    logic [TICK_W-1:0]    r_den;
    logic [TICK_W-1:0]    r_rem;
    logic [TICK_W:0]      w_shift;
    logic                 w_ge;
    logic [TICK_W:0]      w_diff;

    assign w_shift = {r_rem, r_num[TICK_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {MOD_CNT_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[TICK_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[TICK_W-1:0] : w_shift[TICK_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> design/ptts_checker.sv
// Port-level checker for the periodic task tick scheduler and its bind.
module ptts_checker
    import ptts_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("Stalled output transaction changed or dropped.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input accepted a second transaction without a busy cycle.");

    a_due_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == KIND_DUE) |-> o_out_item.status == STATUS_OK)
        else $error("Due transaction carries a rejected status.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Output or input side busy right after reset.");

endmodule

bind periodic_task_tick_scheduler_core ptts_checker u_ptts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
